[design/sqv_pkg.sv]
// ----------------------------------------------------------------------------
// sqv_pkg
// Shared types, constants and helpers for the sprite quad vertex setup block.
// ----------------------------------------------------------------------------
package sqv_pkg;

	localparam int ANGLE_BITS_DEF = 16;

	// odd sine polynomial coefficients, Q30
	localparam logic signed [31:0] C1 = 32'sd1686629713;
	localparam logic signed [31:0] C3 = -32'sd693598668;
	localparam logic signed [31:0] C5 = 32'sd85569306;
	localparam logic signed [31:0] C7 = -32'sd5026995;
	localparam logic signed [31:0] C9 = 32'sd172272;

	localparam int SIN_LAT    = 7;
	localparam int Q_BITS     = 17;
	localparam int DIV_LAT    = Q_BITS + 1;
	localparam int REM_W      = 35;
	localparam int DIV_W      = 17;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	localparam logic [1:0] CORNER_TL = 2'd0;
	localparam logic [1:0] CORNER_BL = 2'd1;
	localparam logic [1:0] CORNER_TR = 2'd2;
	localparam logic [1:0] CORNER_BR = 2'd3;

	localparam logic [1:0] CFG_SCREEN_W = 2'd0;
	localparam logic [1:0] CFG_SCREEN_H = 2'd1;
	localparam logic [1:0] CFG_COLOR    = 2'd2;

	typedef struct packed {
		logic signed [15:0] px;
		logic signed [15:0] py;
		logic [15:0]        pz;
		logic signed [15:0] cx;
		logic signed [15:0] cy;
		logic [14:0]        w;
		logic [14:0]        h;
		logic [15:0]        u0;
		logic [15:0]        v0;
		logic [15:0]        uw;
		logic [15:0]        vh;
		logic signed [15:0] sn;
		logic signed [15:0] cs;
	} sqv_sprite_t;

	typedef struct packed {
		logic [13:0] screen_w;
		logic [13:0] screen_h;
		logic [31:0] color;
	} sqv_cfg_t;

	typedef struct packed {
		logic [1:0]         corner;
		logic signed [15:0] ndc_x;
		logic signed [15:0] ndc_y;
		logic [15:0]        depth;
		logic [16:0]        tex_u;
		logic [16:0]        tex_v;
		logic [31:0]        rgba;
		logic               last;
	} sqv_vertex_t;

	function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
		if (v < -19'sd32768) return -16'sd32768;
		if (v > 19'sd32767) return 16'sd32767;
		return v[15:0];
	endfunction

endpackage

[design/sqv_sine.sv]
// ----------------------------------------------------------------------------
// sqv_sine
// Pipelined Q14 sine of a 16 bit phase, odd polynomial by Horner steps.
// ----------------------------------------------------------------------------
module sqv_sine (
	input  logic               clk,
	input  logic               en,
	input  logic [15:0]        phase,
	output logic signed [15:0] sine
);

	localparam logic signed [31:0] C9_L = sqv_pkg::C9;
	localparam logic signed [31:0] C7_L = sqv_pkg::C7;

	function automatic logic signed [31:0] horner(input logic signed [31:0] acc,
		input logic [15:0] t2, input logic signed [31:0] c);
		logic signed [48:0] p;
		p = acc * $signed({1'b0, t2});
		p = p >>> 14;
		return c + p[31:0];
	endfunction

	logic [14:0]        fold;
	logic [29:0]        sq;
	logic [14:0]        f_s1, f_s2, f_s3, f_s4, f_s5;
	logic [15:0]        t2_s1, t2_s2, t2_s3, t2_s4;
	logic               neg_s1, neg_s2, neg_s3, neg_s4, neg_s5, neg_s6;
	logic signed [31:0] acc_s2, acc_s3, acc_s4, acc_s5;
	logic signed [47:0] prod;
	logic signed [33:0] r_s6;
	logic signed [33:0] rr;

	// mirror the second and fourth quarter
	assign fold = phase[14] ? 15'd16384 - {1'b0, phase[13:0]} : {1'b0, phase[13:0]};
	assign sq   = fold * fold;
	assign prod = acc_s5 * $signed({1'b0, f_s5});
	assign rr   = (r_s6 + 34'sd32768) >>> 16;

	always_ff @(posedge clk) begin
		if (en) begin
			f_s1   <= fold;
			t2_s1  <= sq[29:14];
			neg_s1 <= phase[15];
			acc_s2 <= horner(C9_L, t2_s1, C7_L);
			f_s2   <= f_s1;
			t2_s2  <= t2_s1;
			neg_s2 <= neg_s1;
			acc_s3 <= horner(acc_s2, t2_s2, sqv_pkg::C5);
			f_s3   <= f_s2;
			t2_s3  <= t2_s2;
			neg_s3 <= neg_s2;
			acc_s4 <= horner(acc_s3, t2_s3, sqv_pkg::C3);
			f_s4   <= f_s3;
			t2_s4  <= t2_s3;
			neg_s4 <= neg_s3;
			acc_s5 <= horner(acc_s4, t2_s4, sqv_pkg::C1);
			f_s5   <= f_s4;
			neg_s5 <= neg_s4;
			r_s6   <= 34'(prod >>> 14);
			neg_s6 <= neg_s5;
			if (rr < 0) begin
				sine <= 16'sd0;
			end else if (rr > 34'sd16384) begin
				sine <= neg_s6 ? -16'sd16384 : 16'sd16384;
			end else begin
				sine <= neg_s6 ? -$signed(rr[15:0]) : $signed(rr[15:0]);
			end
		end
	end

endmodule

[design/sqv_front.sv]
// ----------------------------------------------------------------------------
// sqv_front
// Accept sprite requests, look up sine and cosine, hand records to the queue.
// ----------------------------------------------------------------------------
module sqv_front #(
	parameter int ANGLE_BITS = sqv_pkg::ANGLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  sqv_pkg::sqv_sprite_t   in_rec,
	input  logic [ANGLE_BITS-1:0]  angle,
	output logic                   out_valid,
	input  logic                   out_ready,
	output sqv_pkg::sqv_sprite_t   out_rec
);

	localparam int L = sqv_pkg::SIN_LAT;

	logic [15:0]          phase;
	logic                 en;
	logic                 vld_s [L];
	sqv_pkg::sqv_sprite_t rec_s [L];
	logic signed [15:0]   sn, cs;

	generate
		if (ANGLE_BITS >= 16) begin : g_shr
			assign phase = angle[ANGLE_BITS-1 -: 16];
		end else begin : g_shl
			assign phase = {angle, {(16 - ANGLE_BITS){1'b0}}};
		end
	endgenerate

	// advance unless the finished record is blocked by a full queue
	assign en       = !vld_s[L-1] || out_ready;
	assign in_ready = en;

	sqv_sine u_sin (.clk(clk), .en(en), .phase(phase), .sine(sn));
	sqv_sine u_cos (.clk(clk), .en(en), .phase(phase + 16'd16384), .sine(cs));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < L; i++) vld_s[i] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int i = 1; i < L; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rec_s[0] <= in_rec;
			for (int i = 1; i < L; i++) rec_s[i] <= rec_s[i-1];
		end
	end

	always_comb begin
		out_rec    = rec_s[L-1];
		out_rec.sn = sn;
		out_rec.cs = cs;
	end
	assign out_valid = vld_s[L-1];

endmodule

[design/sqv_fifo.sv]
// ----------------------------------------------------------------------------
// sqv_fifo
// Short queue of sprite records between the front and the back.
// ----------------------------------------------------------------------------
module sqv_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  sqv_pkg::sqv_sprite_t in_rec,
	output logic                 out_valid,
	input  logic                 out_ready,
	output sqv_pkg::sqv_sprite_t out_rec
);

	localparam int AW = sqv_pkg::FIFO_AW;

	sqv_pkg::sqv_sprite_t mem_q [sqv_pkg::FIFO_DEPTH];
	logic [AW-1:0]        wr_q, rd_q;
	logic [AW:0]          cnt_q;
	logic                 push, pop;

	assign in_ready  = cnt_q != (AW + 1)'(sqv_pkg::FIFO_DEPTH);
	assign out_valid = cnt_q != '0;
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_rec   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (AW + 1)'(push) - (AW + 1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_rec;
	end

endmodule

[design/sqv_div.sv]
// ----------------------------------------------------------------------------
// sqv_div
// Pipelined restoring divider, one quotient bit per stage, saturating.
// ----------------------------------------------------------------------------
module sqv_div (
	input  logic                       clk,
	input  logic                       en,
	input  logic [sqv_pkg::REM_W-1:0]  m,
	input  logic [sqv_pkg::DIV_W-1:0]  d,
	output logic [sqv_pkg::Q_BITS-1:0] q
);

	localparam int QB = sqv_pkg::Q_BITS;
	localparam int RW = sqv_pkg::REM_W;

	logic [RW-1:0] rem_s [QB+1];
	logic [QB-1:0] q_s   [QB+1];
	logic          ovf;

	// quotient too large for the result range: force all ones
	assign ovf = m >= (RW'(d) << QB);

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= ovf ? '0 : m;
			q_s[0]   <= ovf ? '1 : '0;
		end
	end

	generate
		for (genvar i = 1; i <= QB; i++) begin : g_stage
			localparam int B = QB - i;
			logic [RW-1:0] dsh;
			logic          ge;
			logic [QB-1:0] qn;
			assign dsh = RW'(d) << B;
			assign ge  = rem_s[i-1] >= dsh;
			always_comb begin
				qn    = q_s[i-1];
				qn[B] = qn[B] | ge;
			end
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[i] <= ge ? rem_s[i-1] - dsh : rem_s[i-1];
					q_s[i]   <= qn;
				end
			end
		end
	endgenerate

	assign q = q_s[QB];

endmodule

[design/sqv_back.sv]
// ----------------------------------------------------------------------------
// sqv_back
// Expand a sprite record to four corners, rotate, normalize, saturate.
// ----------------------------------------------------------------------------
module sqv_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sqv_pkg::sqv_cfg_t    cfg,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  sqv_pkg::sqv_sprite_t in_rec,
	output logic                 out_valid,
	input  logic                 out_ready,
	output sqv_pkg::sqv_vertex_t out_vtx
);

	localparam int DL = sqv_pkg::DIV_LAT;
	localparam int RW = sqv_pkg::REM_W;

	typedef struct packed {
		logic [1:0]  corner;
		logic        last;
		logic [15:0] depth;
		logic [16:0] tex_u;
		logic [16:0] tex_v;
	} side_t;

	logic               en, issue, right, bottom;
	logic [1:0]         corner_q;
	logic [13:0]        sw, sh;
	logic [16:0]        dx, dy;

	logic               vld_s1, vld_s2, vld_s3, vld_s4;
	side_t              side_s1, side_s2, side_s3, side_s4;
	logic signed [17:0] lx_s1, ly_s1;
	logic signed [15:0] sn_s1, cs_s1, px_s1, py_s1, px_s2, py_s2;
	logic signed [33:0] plc_s2, pls_s2, pyc_s2, pys_s2;
	logic signed [35:0] rx_s3, ry_s3;
	logic signed [35:0] nx, ny;
	logic [RW-1:0]      mx_s4, my_s4;
	logic               negx_s4, negy_s4;

	logic               vld_d  [DL];
	side_t              side_d [DL];
	logic               negx_d [DL];
	logic               negy_d [DL];
	logic [16:0]        qx, qy;
	logic signed [18:0] resx, resy;

	logic               out_vld_q;
	sqv_pkg::sqv_vertex_t vtx_q;

	assign en       = !out_vld_q || out_ready;
	assign issue    = en && in_valid;
	assign in_ready = en && corner_q == sqv_pkg::CORNER_BR;
	assign right    = corner_q[1];
	assign bottom   = corner_q[0];

	// zero screen size counts as one pixel
	assign sw = cfg.screen_w == '0 ? 14'd1 : cfg.screen_w;
	assign sh = cfg.screen_h == '0 ? 14'd1 : cfg.screen_h;
	assign dx = {sw, 3'b000};
	assign dy = {sh, 3'b000};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corner_q  <= sqv_pkg::CORNER_TL;
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			out_vld_q <= 1'b0;
			for (int i = 0; i < DL; i++) vld_d[i] <= 1'b0;
		end else begin
			if (issue) corner_q <= corner_q + 2'd1;
			if (en) begin
				vld_s1    <= in_valid;
				vld_s2    <= vld_s1;
				vld_s3    <= vld_s2;
				vld_s4    <= vld_s3;
				vld_d[0]  <= vld_s4;
				for (int i = 1; i < DL; i++) vld_d[i] <= vld_d[i-1];
				out_vld_q <= vld_d[DL-1];
			end
		end
	end

	assign nx = rx_s3 + 36'(sw) * 36'sd4;
	assign ny = ry_s3 + 36'(sh) * 36'sd4;

	always_ff @(posedge clk) begin
		if (en) begin
			// corner offset from the pivot
			lx_s1 <= -$signed({{2{in_rec.cx[15]}}, in_rec.cx})
				+ (right ? $signed({3'b000, in_rec.w}) : 18'sd0);
			ly_s1 <= -$signed({{2{in_rec.cy[15]}}, in_rec.cy})
				+ (bottom ? $signed({3'b000, in_rec.h}) : 18'sd0);
			sn_s1 <= in_rec.sn;
			cs_s1 <= in_rec.cs;
			px_s1 <= in_rec.px;
			py_s1 <= in_rec.py;
			side_s1.corner <= corner_q;
			side_s1.last   <= corner_q == sqv_pkg::CORNER_BR;
			side_s1.depth  <= in_rec.pz;
			side_s1.tex_u  <= right ? 17'(in_rec.u0) + 17'(in_rec.uw) : 17'(in_rec.u0);
			side_s1.tex_v  <= bottom ? 17'(in_rec.v0) + 17'(in_rec.vh) : 17'(in_rec.v0);

			plc_s2  <= lx_s1 * cs_s1;
			pls_s2  <= lx_s1 * sn_s1;
			pyc_s2  <= ly_s1 * cs_s1;
			pys_s2  <= ly_s1 * sn_s1;
			px_s2   <= px_s1;
			py_s2   <= py_s1;
			side_s2 <= side_s1;

			rx_s3   <= 36'(plc_s2) - 36'(pys_s2) + (36'(px_s2) <<< 14);
			ry_s3   <= 36'(pls_s2) + 36'(pyc_s2) + (36'(py_s2) <<< 14);
			side_s3 <= side_s2;

			// floor division of a negative value through its complement
			negx_s4 <= nx[35];
			negy_s4 <= ny[35];
			mx_s4   <= nx[35] ? ~nx[RW-1:0] : nx[RW-1:0];
			my_s4   <= ny[35] ? ~ny[RW-1:0] : ny[RW-1:0];
			side_s4 <= side_s3;

			side_d[0] <= side_s4;
			negx_d[0] <= negx_s4;
			negy_d[0] <= negy_s4;
			for (int i = 1; i < DL; i++) begin
				side_d[i] <= side_d[i-1];
				negx_d[i] <= negx_d[i-1];
				negy_d[i] <= negy_d[i-1];
			end

			vtx_q.corner <= side_d[DL-1].corner;
			vtx_q.last   <= side_d[DL-1].last;
			vtx_q.depth  <= side_d[DL-1].depth;
			vtx_q.tex_u  <= side_d[DL-1].tex_u;
			vtx_q.tex_v  <= side_d[DL-1].tex_v;
			vtx_q.rgba   <= cfg.color;
			vtx_q.ndc_x  <= sqv_pkg::sat16(resx - 19'sd16384);
			vtx_q.ndc_y  <= sqv_pkg::sat16(19'sd16384 - resy);
		end
	end

	sqv_div u_divx (.clk(clk), .en(en), .m(mx_s4), .d(dx), .q(qx));
	sqv_div u_divy (.clk(clk), .en(en), .m(my_s4), .d(dy), .q(qy));

	assign resx = negx_d[DL-1] ? -19'sd1 - $signed({2'b00, qx}) : $signed({2'b00, qx});
	assign resy = negy_d[DL-1] ? -19'sd1 - $signed({2'b00, qy}) : $signed({2'b00, qy});

	assign out_valid = out_vld_q;
	assign out_vtx   = vtx_q;

endmodule

[design/sprite_quad_vertex_setup.sv]
// ----------------------------------------------------------------------------
// sprite_quad_vertex_setup
// Rotated sprite quad to normalized device coordinate vertex setup.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one sprite request per word. Each request yields four
//   vertex words on m_axis in the order top-left, bottom-left, top-right,
//   bottom-right; tuser holds the corner and tlast marks the fourth vertex.
//   cfg writes screen width (index 0), screen height (1) and color (2);
//   write them only while no sprite is in flight.
// Rate: the back end feeds the single vertex channel with one corner per
//   cycle while the output is not stalled, and takes the next request
//   from the queue as it issues the bottom-right corner of the current one.
// Path: the sine/cosine pipeline in the front, the queue, then corner
//   setup, rotation and offset, the divider pipeline and the output
//   register lie between the request word and its first vertex.
// Reset: arst_n clears all valid flags and the queue; the screen size
//   returns to 1280 x 720 and the color to all ones.
// Stall: when m_axis_tready is low the back pipeline holds; the queue
//   absorbs up to four requests, then the front holds and s_axis_tready drops.
// ----------------------------------------------------------------------------
module sprite_quad_vertex_setup #(
	parameter int ANGLE_BITS = sqv_pkg::ANGLE_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	// pos_x, pos_y, pos_z, pivot_x, pivot_y, size_w, size_h,
	// uv_left, uv_top, uv_width, uv_height, angle, zero pad
	input  logic [((174 + ANGLE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	// ndc_x, ndc_y, depth, tex_u, tex_v, rgba, zero pad
	output logic [119:0]        m_axis_tdata,
	// corner
	output logic [1:0]          m_axis_tuser,
	output logic                m_axis_tlast,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data
);

	sqv_pkg::sqv_cfg_t    cfg_q;
	sqv_pkg::sqv_sprite_t in_rec, f2q_rec, q2b_rec;
	sqv_pkg::sqv_vertex_t vtx;
	logic                 f2q_valid, f2q_ready, q2b_valid, q2b_ready;
	logic [1:0]           exp_corner_q;

	// configuration: always ready, unknown index dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.screen_w <= 14'd1280;
			cfg_q.screen_h <= 14'd720;
			cfg_q.color    <= 32'hFFFF_FFFF;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				sqv_pkg::CFG_SCREEN_W: cfg_q.screen_w <= cfg_data[13:0];
				sqv_pkg::CFG_SCREEN_H: cfg_q.screen_h <= cfg_data[13:0];
				sqv_pkg::CFG_COLOR:    cfg_q.color    <= cfg_data;
				default: ;
			endcase
		end
	end

	// unpack the request word
	always_comb begin
		in_rec.px = s_axis_tdata[15:0];
		in_rec.py = s_axis_tdata[31:16];
		in_rec.pz = s_axis_tdata[47:32];
		in_rec.cx = s_axis_tdata[63:48];
		in_rec.cy = s_axis_tdata[79:64];
		in_rec.w  = s_axis_tdata[94:80];
		in_rec.h  = s_axis_tdata[109:95];
		in_rec.u0 = s_axis_tdata[125:110];
		in_rec.v0 = s_axis_tdata[141:126];
		in_rec.uw = s_axis_tdata[157:142];
		in_rec.vh = s_axis_tdata[173:158];
		in_rec.sn = '0;
		in_rec.cs = '0;
	end

	sqv_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_rec    (in_rec),
		.angle     (s_axis_tdata[174 +: ANGLE_BITS]),
		.out_valid (f2q_valid),
		.out_ready (f2q_ready),
		.out_rec   (f2q_rec)
	);

	sqv_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f2q_valid),
		.in_ready  (f2q_ready),
		.in_rec    (f2q_rec),
		.out_valid (q2b_valid),
		.out_ready (q2b_ready),
		.out_rec   (q2b_rec)
	);

	sqv_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (q2b_valid),
		.in_ready  (q2b_ready),
		.in_rec    (q2b_rec),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_vtx   (vtx)
	);

	// pack the vertex word
	assign m_axis_tdata = {6'b0, vtx.rgba, vtx.tex_v, vtx.tex_u, vtx.depth,
		vtx.ndc_y, vtx.ndc_x};
	assign m_axis_tuser = vtx.corner;
	assign m_axis_tlast = vtx.last;

	// track the corner the next vertex word must carry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_corner_q <= sqv_pkg::CORNER_TL;
		end else if (m_axis_tvalid && m_axis_tready) begin
			exp_corner_q <= exp_corner_q + 2'd1;
		end
	end

	a_corner_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser == exp_corner_q)
		else $error("vertex corner out of order");

	a_last_on_br: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == sqv_pkg::CORNER_BR)))
		else $error("tlast not on bottom-right vertex");

endmodule

[dv/sprite_quad_vertex_setup_tb.sv]
// ----------------------------------------------------------------------------
// sprite_quad_vertex_setup_tb
// Self-checking bench for the sprite quad vertex setup block. Sprite words go
// in on s_axis with random gaps. Each accepted word is expanded by a local
// fixed-point model into four expected vertices. Every vertex word on m_axis
// is compared field by field with the oldest expected vertex. The screen
// size and color registers are swept between phases, while the block is idle.
// ----------------------------------------------------------------------------
module sprite_quad_vertex_setup_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IN_W      = 192;
	localparam int SETTLE    = 40;   // idle wait in drain after the last expected vertex
	localparam int LONG_HOLD = 120;

	typedef struct {
		logic signed [15:0] px, py;
		logic [15:0]        pz;
		logic signed [15:0] cx, cy;
		logic [14:0]        w, h;
		logic [15:0]        u0, v0, uw, vh;
		logic [15:0]        angle;
	} sprite_req_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [IN_W-1:0]   s_axis_tdata = '0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [119:0]      m_axis_tdata;
	logic [1:0]        m_axis_tuser;
	logic              m_axis_tlast;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [1:0]        cfg_index = '0;
	logic [31:0]       cfg_data = '0;

	// local copy of the registers
	logic [13:0] scr_w_q, scr_h_q;
	logic [31:0] color_q;

	sqv_pkg::sqv_vertex_t vertex_q[$];
	int          errors = 0;
	int          sprites_sent = 0;
	int          vertices_seen = 0;
	bit          no_idle = 0;     // both sides run at full rate when set
	int          hold_cycles = 0; // long receiver hold-off request

	sprite_quad_vertex_setup uut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ---------------------------------------------------------------- model
	function automatic longint floor_div(longint n, longint d);
		if (n >= 0) return n / d;
		return -1 - ((-1 - n) / d);
	endfunction

	function automatic longint quarter_sin(longint f);
		longint t2, acc, r;
		t2  = (f * f) >>> 14;
		acc = sqv_pkg::C9;
		acc = sqv_pkg::C7 + ((acc * t2) >>> 14);
		acc = sqv_pkg::C5 + ((acc * t2) >>> 14);
		acc = sqv_pkg::C3 + ((acc * t2) >>> 14);
		acc = sqv_pkg::C1 + ((acc * t2) >>> 14);
		r = (acc * f) >>> 14;
		r = (r + 32768) >>> 16;
		if (r < 0) r = 0;
		if (r > 16384) r = 16384;
		return r;
	endfunction

	function automatic longint phase_sin(logic [15:0] p);
		longint s;
		longint f;
		f = longint'(p[13:0]);
		s = p[14] ? quarter_sin(16384 - f) : quarter_sin(f);
		return p[15] ? -s : s;
	endfunction

	function automatic logic [15:0] clamp16(longint v);
		if (v < -32768) return 16'h8000;
		if (v > 32767) return 16'h7fff;
		return v[15:0];
	endfunction

	// expand one sprite into its four corner vertices
	task automatic predict_quad(sprite_req_t r);
		longint sn, cs, dw, dh, lx, ly, rx, ry;
		sqv_pkg::sqv_vertex_t v;
		bit right, bottom;
		sn = phase_sin(r.angle);
		cs = phase_sin(r.angle + 16'h4000);
		dw = longint'(scr_w_q == 0 ? 14'd1 : scr_w_q) * 8;
		dh = longint'(scr_h_q == 0 ? 14'd1 : scr_h_q) * 8;
		for (int k = 0; k < 4; k++) begin
			right  = k[1];
			bottom = k[0];
			lx = -longint'(r.cx) + (right ? longint'(r.w) : 0);
			ly = -longint'(r.cy) + (bottom ? longint'(r.h) : 0);
			rx = lx * cs - ly * sn + longint'(r.px) * 16384;
			ry = lx * sn + ly * cs + longint'(r.py) * 16384;
			v.corner = k[1:0];
			v.ndc_x  = clamp16(floor_div(rx + dw / 2, dw) - 16384);
			v.ndc_y  = clamp16(16384 - floor_div(ry + dh / 2, dh));
			v.depth  = r.pz;
			v.tex_u  = right ? {1'b0, r.u0} + r.uw : {1'b0, r.u0};
			v.tex_v  = bottom ? {1'b0, r.v0} + r.vh : {1'b0, r.v0};
			v.rgba   = color_q;
			v.last   = (k == 3);
			vertex_q.push_back(v);
		end
	endtask

	// ---------------------------------------------------------------- driver
	task automatic send_sprite(sprite_req_t r);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			@(negedge clk) s_axis_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {2'b0, r.angle, r.vh, r.uw, r.v0, r.u0, r.h, r.w,
			r.cy, r.cx, r.pz, r.py, r.px};
		// hold the word until it is taken
		do @(posedge clk); while (!s_axis_tready);
		predict_quad(r);
		sprites_sent++;
	endtask

	task automatic stop_sending();
		@(negedge clk) s_axis_tvalid <= 1'b0;
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			sqv_pkg::CFG_SCREEN_W: scr_w_q = data[13:0];
			sqv_pkg::CFG_SCREEN_H: scr_h_q = data[13:0];
			sqv_pkg::CFG_COLOR:    color_q = data;
			default: ; // unknown index: drop
		endcase
		@(negedge clk) cfg_valid <= 1'b0;
	endtask

	// wait until every expected vertex is out, then let the pipe settle
	task automatic drain();
		stop_sending();
		while (vertex_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic sprite_req_t rand_sprite();
		sprite_req_t r;
		r.px = 16'($urandom); r.py = 16'($urandom); r.pz = 16'($urandom);
		r.u0 = 16'($urandom); r.v0 = 16'($urandom);
		r.uw = 16'($urandom); r.vh = 16'($urandom);
		r.angle = 16'($urandom);
		if ($urandom_range(0, 3) == 0) begin
			r.cx = 16'($urandom); r.cy = 16'($urandom);
			r.w  = 15'($urandom); r.h  = 15'($urandom);
		end else begin
			// on-screen sized sprites so that most vertices do not saturate
			r.px = 16'($urandom_range(0, 16'h4fff));
			r.py = 16'($urandom_range(0, 16'h2fff));
			r.w  = 15'($urandom_range(0, 16'h0fff));
			r.h  = 15'($urandom_range(0, 16'h0fff));
			r.cx = $signed(16'($urandom_range(0, 16'h1000))) - 16'sh0800;
			r.cy = $signed(16'($urandom_range(0, 16'h1000))) - 16'sh0800;
		end
		return r;
	endfunction

	// ---------------------------------------------------------------- receiver
	initial begin
		int gap;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				m_axis_tready <= 1'b0;
				hold_cycles--;
			end else begin
				gap = no_idle ? 0 : $urandom_range(0, 7);
				if (gap > 0) begin
					m_axis_tready <= 1'b0;
					repeat (gap - 1) @(negedge clk);
					@(negedge clk);
				end
				m_axis_tready <= 1'b1;
				do @(posedge clk); while (!m_axis_tvalid);
			end
		end
	end

	// ---------------------------------------------------------------- checker
	task automatic report(string what, longint got, longint want);
		$display("ERROR %0t: vertex %0d %s got %0h want %0h",
			$realtime, vertices_seen, what, got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		sqv_pkg::sqv_vertex_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (vertex_q.size() == 0) begin
				report("unexpected word", m_axis_tdata[31:0], 0);
			end else begin
				e = vertex_q.pop_front();
				if (m_axis_tuser !== e.corner) report("corner", m_axis_tuser, e.corner);
				if (m_axis_tdata[15:0] !== e.ndc_x)
					report("ndc_x", m_axis_tdata[15:0], e.ndc_x);
				if (m_axis_tdata[31:16] !== e.ndc_y)
					report("ndc_y", m_axis_tdata[31:16], e.ndc_y);
				if (m_axis_tdata[47:32] !== e.depth)
					report("depth", m_axis_tdata[47:32], e.depth);
				if (m_axis_tdata[64:48] !== e.tex_u)
					report("tex_u", m_axis_tdata[64:48], e.tex_u);
				if (m_axis_tdata[81:65] !== e.tex_v)
					report("tex_v", m_axis_tdata[81:65], e.tex_v);
				if (m_axis_tdata[113:82] !== e.rgba)
					report("rgba", m_axis_tdata[113:82], e.rgba);
				if (m_axis_tdata[119:114] !== 6'b0)
					report("pad", m_axis_tdata[119:114], 0);
				if (m_axis_tlast !== e.last) report("last", m_axis_tlast, e.last);
			end
			vertices_seen++;
		end
	end

	// ---------------------------------------------------------------- tests
	task automatic test_directed();
		sprite_req_t r;
		logic [15:0] angles[8] = '{16'h0000, 16'h4000, 16'h8000, 16'hc000,
			16'h2000, 16'h3fff, 16'hffff, 16'h0001};
		// corner extremes of every field
		r = '{16'sh7fff, 16'sh7fff, 16'h7fff, 16'sh8000, 16'sh8000, 15'h7fff,
			15'h7fff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'h0000};
		send_sprite(r);
		r = '{16'sh8000, 16'sh8000, 16'h8000, 16'sh7fff, 16'sh7fff, 15'h7fff,
			15'h7fff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'h8000};
		send_sprite(r);
		r = '{16'sh0, 16'sh0, 16'h0, 16'sh0, 16'sh0, 15'h0, 15'h0,
			16'h0, 16'h0, 16'h0, 16'h0, 16'h0};
		send_sprite(r);
		// screen center, rotated through the quadrant edges
		foreach (angles[i]) begin
			r = '{16'sd10240, 16'sd5760, 16'h1234, 16'sd256, 16'sd128, 15'd512,
				15'd256, 16'h1000, 16'h2000, 16'h4000, 16'h8000, angles[i]};
			send_sprite(r);
		end
		drain();
	endtask

	task automatic test_config_sweep();
		logic [31:0] widths[5] = '{32'd0, 32'd1, 32'd8192, 32'hffff_ffff, 32'd640};
		logic [31:0] heights[5] = '{32'd0, 32'd8192, 32'd1, 32'hffff_c000, 32'd480};
		logic [31:0] colors[5] = '{32'h0, 32'hffff_ffff, 32'h1234_5678,
			32'h8000_0001, 32'hdead_beef};
		foreach (widths[i]) begin
			write_reg(sqv_pkg::CFG_SCREEN_W, widths[i]);
			write_reg(sqv_pkg::CFG_SCREEN_H, heights[i]);
			write_reg(sqv_pkg::CFG_COLOR, colors[i]);
			write_reg(2'd3, $urandom); // unknown index, must be ignored
			repeat (3) send_sprite(rand_sprite());
			drain();
		end
		write_reg(sqv_pkg::CFG_SCREEN_W, 32'd1280);
		write_reg(sqv_pkg::CFG_SCREEN_H, 32'd720);
	endtask

	task automatic test_random(int n);
		for (int i = 0; i < n; i++) begin
			// stretches of back-to-back traffic on both sides
			if (i % 80 == 40) no_idle = 1;
			if (i % 80 == 60) no_idle = 0;
			send_sprite(rand_sprite());
		end
		no_idle = 0;
		drain();
	endtask

	task automatic test_backpressure();
		hold_cycles = LONG_HOLD;
		no_idle = 1;
		for (int i = 0; i < 20; i++) send_sprite(rand_sprite());
		no_idle = 0;
		drain();
	endtask

	initial begin
		scr_w_q = 14'd1280;
		scr_h_q = 14'd720;
		color_q = 32'hffff_ffff;
		repeat (10) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_directed();
		test_config_sweep();
		test_backpressure();
		test_random(200);
		write_reg(sqv_pkg::CFG_SCREEN_W, 32'd333);
		write_reg(sqv_pkg::CFG_SCREEN_H, 32'd8191);
		write_reg(sqv_pkg::CFG_COLOR, $urandom);
		test_random(210);

		$display("covered %0d sprites, %0d vertex words, register sweep incl. zero,",
			sprites_sent, vertices_seen);
		$display("oversize and unknown-index writes, long output hold-off");
		if (errors == 0) begin
			$display("sprite_quad_vertex_setup test passed");
		end else begin
			$display("sprite_quad_vertex_setup test failed");
		end
		$finish;
	end

	initial begin
		#2ms;
		$display("sprite_quad_vertex_setup test failed");
		$finish;
	end

endmodule
